FILE: hdl/ps2hq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 host port package
// Shared opcodes, frame positions and the status word that flows down the
// pipeline.
// ----------------------------------------------------------------------------
package ps2hq_pkg;

  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_SEND = 2'd1,
    OP_POP  = 2'd2,
    OP_NOP  = 2'd3
  } ps2hq_op_e;

  localparam int unsigned BitPosW = 4;

  // Frame positions used by the bit counter.
  localparam logic [BitPosW-1:0] PosFirst  = 4'd1;
  localparam logic [BitPosW-1:0] PosRxLast = 4'd9;
  localparam logic [BitPosW-1:0] PosTxLast = 4'd8;
  localparam logic [BitPosW-1:0] PosParity = 4'd9;
  localparam logic [BitPosW-1:0] PosRxPar  = 4'd10;
  localparam logic [BitPosW-1:0] PosStop   = 4'd10;
  localparam logic [BitPosW-1:0] PosEnd    = 4'd11;

  typedef struct packed {
    logic drive_data_low;
    logic request_to_send;
    logic send_rejected;
    logic sending;
    logic send_done;
    logic code_queued;
    logic parity_error;
    logic queue_overflow;
    logic popped_valid;
    logic queue_empty;
  } ps2hq_status_t;

endpackage : ps2hq_pkg
`default_nettype wire

FILE: hdl/ps2hq_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scancode ring memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ps2hq_ring #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PtrW        = 4
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [PtrW-1:0] wr_addr_i,
  input  wire logic [7:0]      wr_data_i,
  input  wire logic            rd_en_i,
  input  wire logic [PtrW-1:0] rd_addr_i,
  output logic      [7:0]      rd_data_o
);

  logic [7:0] mem_q [QUEUE_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : ps2hq_ring
`default_nettype wire

FILE: hdl/ps2hq_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 frame engine
// Bit counter, shift byte, parity and ring pointers; issues ring accesses
// and forms the status word of each accepted word.
// ----------------------------------------------------------------------------
module ps2hq_frame #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PtrW        = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    fire_i,
  input  wire logic [1:0]              opcode_i,
  input  wire logic                    data_line_i,
  input  wire logic [7:0]              send_byte_i,
  output ps2hq_pkg::ps2hq_status_t     status_o,
  output logic                         wr_en_o,
  output logic      [PtrW-1:0]         wr_addr_o,
  output logic      [7:0]              wr_data_o,
  output logic                         rd_en_o,
  output logic      [PtrW-1:0]         rd_addr_o
);
  import ps2hq_pkg::*;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  logic [BitPosW-1:0] bit_pos_q, bit_pos_d, pos;
  logic               parity_q, parity_d;
  logic [7:0]         shift_q, shift_d;
  logic               rx_par_q, rx_par_d;
  logic               active_q, active_d;
  logic               pull_q, pull_d;
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, wr_ptr_inc;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d, rd_ptr_inc;
  logic [2:0]         tx_idx, rx_idx;
  ps2hq_op_e          op;

  assign op         = ps2hq_op_e'(opcode_i);
  assign wr_ptr_inc = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
  assign rd_ptr_inc = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
  assign tx_idx     = 3'(bit_pos_q - PosFirst);
  assign rx_idx     = 3'(bit_pos_q - 4'd2);

  always_comb begin
    bit_pos_d = bit_pos_q;
    parity_d  = parity_q;
    shift_d   = shift_q;
    rx_par_d  = rx_par_q;
    active_d  = active_q;
    pull_d    = pull_q;
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    pos       = bit_pos_q;
    wr_en_o   = 1'b0;
    rd_en_o   = 1'b0;
    status_o  = '0;

    unique case (op)
      OP_EDGE: begin
        if (active_q) begin
          if (bit_pos_q >= PosFirst && bit_pos_q <= PosTxLast) begin
            if (shift_q[tx_idx]) begin
              pull_d   = 1'b0;
              parity_d = ~parity_q;
            end else begin
              pull_d = 1'b1;
            end
          end else if (bit_pos_q == PosParity) begin
            pull_d = parity_q;
          end else if (bit_pos_q == PosStop) begin
            pull_d = 1'b0;
          end else if (bit_pos_q == PosEnd) begin
            shift_d            = '0;
            parity_d           = 1'b0;
            active_d           = 1'b0;
            pos                = '0;
            status_o.send_done = 1'b1;
          end
        end else begin
          if (bit_pos_q >= 4'd2 && bit_pos_q <= PosRxLast) begin
            if (data_line_i) begin
              shift_d[rx_idx] = 1'b1;
              parity_d        = ~parity_q;
            end
          end else if (bit_pos_q == PosRxPar) begin
            rx_par_d = data_line_i;
          end else if (bit_pos_q == PosEnd) begin
            if (rx_par_q ^ parity_q) begin
              if (wr_ptr_inc != rd_ptr_q) begin
                wr_en_o              = 1'b1;
                wr_ptr_d             = wr_ptr_inc;
                status_o.code_queued = 1'b1;
              end else begin
                status_o.queue_overflow = 1'b1;
              end
            end else begin
              status_o.parity_error = 1'b1;
            end
            shift_d  = '0;
            rx_par_d = 1'b0;
            parity_d = 1'b0;
            pos      = '0;
          end
        end
        bit_pos_d = pos + BitPosW'(1);
      end
      OP_SEND: begin
        if (active_q) begin
          status_o.send_rejected = 1'b1;
        end else begin
          bit_pos_d                = PosFirst;
          parity_d                 = 1'b0;
          shift_d                  = send_byte_i;
          active_d                 = 1'b1;
          pull_d                   = 1'b1;
          status_o.request_to_send = 1'b1;
        end
      end
      OP_POP: begin
        if (wr_ptr_q != rd_ptr_q) begin
          rd_en_o               = 1'b1;
          rd_ptr_d              = rd_ptr_inc;
          status_o.popped_valid = 1'b1;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase

    status_o.drive_data_low = pull_d;
    status_o.sending        = active_d;
    status_o.queue_empty    = (wr_ptr_d == rd_ptr_d);

    // Ring accesses and the status word only count for an accepted word.
    wr_en_o = wr_en_o & fire_i;
    rd_en_o = rd_en_o & fire_i;
  end

  assign wr_addr_o = wr_ptr_q;
  assign wr_data_o = shift_q;
  assign rd_addr_o = rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_pos_q <= PosFirst;
      parity_q  <= 1'b0;
      shift_q   <= '0;
      rx_par_q  <= 1'b0;
      active_q  <= 1'b0;
      pull_q    <= 1'b0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
    end else if (fire_i) begin
      bit_pos_q <= bit_pos_d;
      parity_q  <= parity_d;
      shift_q   <= shift_d;
      rx_par_q  <= rx_par_d;
      active_q  <= active_d;
      pull_q    <= pull_d;
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
    end
  end

endmodule : ps2hq_frame
`default_nettype wire

FILE: hdl/ps2_host_port_with_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted word's status is registered in stage one while the
// ring read is in flight, then in the output register that drives the ports.
// Throughput: one word per cycle unless the consumer stalls, as the frame
// update is combinational and the read of the ring is registered.
// Reset: bit counter to 1, pointers, flags and pipeline valids cleared;
// the ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// PS/2 host port with scancode queue
// Receives and sends PS/2 frames one device clock edge at a time and keeps
// received scancodes in a ring memory that the user pops.
// ----------------------------------------------------------------------------
module ps2_host_port_with_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic       data_line_i,
  input  wire logic [7:0] send_byte_i,
  // Result channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            drive_data_low_o,
  output logic            request_to_send_o,
  output logic            send_rejected_o,
  output logic            sending_o,
  output logic            send_done_o,
  output logic            code_queued_o,
  output logic            parity_error_o,
  output logic            queue_overflow_o,
  output logic      [7:0] popped_code_o,
  output logic            popped_valid_o,
  output logic            queue_empty_o
);
  import ps2hq_pkg::*;

  // Pointer width covers every ring entry; a depth of two still needs one bit.
  localparam int unsigned PtrW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;

  logic            in_fire;
  logic            s1_adv;
  ps2hq_status_t   status;
  logic            wr_en, rd_en;
  logic [PtrW-1:0] wr_addr, rd_addr;
  logic [7:0]      wr_data, rd_data;

  // Stage one holds the status word while the ring read is in flight; the
  // output stage holds a finished word until the consumer takes it.
  logic            s1_vld_q;
  ps2hq_status_t   s1_stat_q;
  logic            out_vld_q;
  ps2hq_status_t   out_stat_q;
  logic [7:0]      out_code_q;

  // Stage one moves on whenever the output register is free or being drained,
  // so a new word enters every cycle unless the consumer stalls.
  assign s1_adv     = !out_vld_q || out_ready_i;
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  ps2hq_frame #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PtrW       (PtrW)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .opcode_i   (opcode_i),
    .data_line_i(data_line_i),
    .send_byte_i(send_byte_i),
    .status_o   (status),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr)
  );

  // A pop only reads an entry whose write was committed at an earlier edge,
  // and a word is either a write or a read, so no forwarding is needed. The
  // read register is only loaded on an accepted pop, so it holds while
  // stage one is stalled.
  ps2hq_ring #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PtrW       (PtrW)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_fire) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_stat_q <= status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  // Steps that are not successful pops report a zero code.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vld_q) begin
      out_stat_q <= s1_stat_q;
      out_code_q <= s1_stat_q.popped_valid ? rd_data : 8'd0;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign drive_data_low_o  = out_stat_q.drive_data_low;
  assign request_to_send_o = out_stat_q.request_to_send;
  assign send_rejected_o   = out_stat_q.send_rejected;
  assign sending_o         = out_stat_q.sending;
  assign send_done_o       = out_stat_q.send_done;
  assign code_queued_o     = out_stat_q.code_queued;
  assign parity_error_o    = out_stat_q.parity_error;
  assign queue_overflow_o  = out_stat_q.queue_overflow;
  assign popped_code_o     = out_code_q;
  assign popped_valid_o    = out_stat_q.popped_valid;
  assign queue_empty_o     = out_stat_q.queue_empty;

endmodule : ps2_host_port_with_queue
`default_nettype wire

FILE: hdl/ps2hq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 host port port checker
// Watches the top level's ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module ps2hq_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       request_to_send_o,
  input wire logic       send_rejected_o,
  input wire logic       sending_o,
  input wire logic       send_done_o,
  input wire logic       code_queued_o,
  input wire logic       parity_error_o,
  input wire logic       queue_overflow_o,
  input wire logic [7:0] popped_code_o,
  input wire logic       popped_valid_o,
  input wire logic       queue_empty_o,
  input wire logic       drive_data_low_o
);

  // A stalled result word stays valid and keeps its popped code.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(popped_code_o))
    else $error("result word changed while stalled");

  // Each word reports at most one event.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({request_to_send_o, send_rejected_o, send_done_o,
                              code_queued_o, parity_error_o, queue_overflow_o,
                              popped_valid_o}))
    else $error("more than one event in a result word");

  // A code just queued leaves the ring non-empty.
  a_queued_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && code_queued_o |-> !queue_empty_o)
    else $error("queued code but ring reported empty");

  // A new send starts by pulling data low; a finished send is no longer active.
  a_send_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (request_to_send_o || send_done_o) |->
      (request_to_send_o && sending_o && drive_data_low_o) ||
      (send_done_o && !sending_o))
    else $error("send status inconsistent with send event");

endmodule : ps2hq_checker

bind ps2_host_port_with_queue ps2hq_checker u_ps2hq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .request_to_send_o(request_to_send_o),
  .send_rejected_o  (send_rejected_o),
  .sending_o        (sending_o),
  .send_done_o      (send_done_o),
  .code_queued_o    (code_queued_o),
  .parity_error_o   (parity_error_o),
  .queue_overflow_o (queue_overflow_o),
  .popped_code_o    (popped_code_o),
  .popped_valid_o   (popped_valid_o),
  .queue_empty_o    (queue_empty_o),
  .drive_data_low_o (drive_data_low_o)
);
`default_nettype wire

FILE: tb/ps2hq_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 host port result checker
// Watches both channels of the port, works out the status word due for each
// accepted input word and compares every accepted result against it in order.
// ----------------------------------------------------------------------------
module ps2hq_result_check #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [1:0] opcode_i,
  input  wire logic       data_line_i,
  input  wire logic [7:0] send_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic       drive_data_low_i,
  input  wire logic       request_to_send_i,
  input  wire logic       send_rejected_i,
  input  wire logic       sending_i,
  input  wire logic       send_done_i,
  input  wire logic       code_queued_i,
  input  wire logic       parity_error_i,
  input  wire logic       queue_overflow_i,
  input  wire logic [7:0] popped_code_i,
  input  wire logic       popped_valid_i,
  input  wire logic       queue_empty_i,
  output int              mismatch_count_o,
  output int              pending_o
);

  import ps2hq_pkg::*;

  typedef struct packed {
    ps2hq_status_t flags;
    logic [7:0]    code;
  } port_result_t;

  port_result_t results_due[$];

  // Mirror of the port state.
  logic [BitPosW-1:0] bit_pos;
  logic               ones_par;
  logic               rx_par;
  logic               tx_active;
  logic               pull_low;
  logic [7:0]         shift_q;
  logic [7:0]         scan_ring [QUEUE_DEPTH];
  int unsigned        wr_ptr;
  int unsigned        rd_ptr;
  int                 mismatches;

  function automatic int unsigned ring_next(input int unsigned ptr);
    return (ptr + 1) % QUEUE_DEPTH;
  endfunction

  // Applies one word to the mirrored state and returns the status it causes.
  function automatic port_result_t port_status(input ps2hq_op_e op, input logic line,
                                               input logic [7:0] byte_in);
    port_result_t       res;
    logic [BitPosW-1:0] pos;
    res = '0;
    case (op)
      OP_EDGE: begin
        pos = bit_pos;
        if (tx_active) begin
          if (pos >= PosFirst && pos <= PosTxLast) begin
            if (shift_q[pos - PosFirst]) begin
              pull_low = 1'b0;
              ones_par = ~ones_par;
            end else begin
              pull_low = 1'b1;
            end
          end else if (pos == PosParity) begin
            pull_low = ones_par;
          end else if (pos == PosStop) begin
            pull_low = 1'b0;
          end else if (pos == PosEnd) begin
            shift_q             = '0;
            ones_par            = 1'b0;
            tx_active           = 1'b0;
            pos                 = '0;
            res.flags.send_done = 1'b1;
          end
        end else begin
          if (pos > PosFirst && pos <= PosRxLast) begin
            if (line) begin
              shift_q[pos - PosFirst - 1] = 1'b1;
              ones_par = ~ones_par;
            end
          end else if (pos == PosRxPar) begin
            rx_par = line;
          end else if (pos == PosEnd) begin
            if (rx_par ^ ones_par) begin
              if (ring_next(wr_ptr) != rd_ptr) begin
                scan_ring[wr_ptr]     = shift_q;
                wr_ptr                = ring_next(wr_ptr);
                res.flags.code_queued = 1'b1;
              end else begin
                res.flags.queue_overflow = 1'b1;
              end
            end else begin
              res.flags.parity_error = 1'b1;
            end
            shift_q  = '0;
            rx_par   = 1'b0;
            ones_par = 1'b0;
            pos      = '0;
          end
        end
        bit_pos = pos + 1'b1;
      end
      OP_SEND: begin
        if (tx_active) begin
          res.flags.send_rejected = 1'b1;
        end else begin
          bit_pos                   = PosFirst;
          ones_par                  = 1'b0;
          shift_q                   = byte_in;
          tx_active                 = 1'b1;
          pull_low                  = 1'b1;
          res.flags.request_to_send = 1'b1;
        end
      end
      OP_POP: begin
        if (wr_ptr != rd_ptr) begin
          res.code               = scan_ring[rd_ptr];
          res.flags.popped_valid = 1'b1;
          rd_ptr                 = ring_next(rd_ptr);
        end
      end
      default: begin
      end
    endcase
    res.flags.drive_data_low = pull_low;
    res.flags.sending        = tx_active;
    res.flags.queue_empty    = (wr_ptr == rd_ptr);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    port_result_t due;
    if (!rst_ni) begin
      bit_pos    = PosFirst;
      ones_par   = 1'b0;
      rx_par     = 1'b0;
      tx_active  = 1'b0;
      pull_low   = 1'b0;
      shift_q    = '0;
      wr_ptr     = 0;
      rd_ptr     = 0;
      mismatches = 0;
      results_due.delete();
    end else begin
      // Results are checked before the new word is predicted, so a result
      // never meets the expectation pushed at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word arrived with nothing expected", $time);
        end else begin
          due = results_due.pop_front();
          check_field("drive_data_low",  due.flags.drive_data_low,  drive_data_low_i);
          check_field("request_to_send", due.flags.request_to_send, request_to_send_i);
          check_field("send_rejected",   due.flags.send_rejected,   send_rejected_i);
          check_field("sending",         due.flags.sending,         sending_i);
          check_field("send_done",       due.flags.send_done,       send_done_i);
          check_field("code_queued",     due.flags.code_queued,     code_queued_i);
          check_field("parity_error",    due.flags.parity_error,    parity_error_i);
          check_field("queue_overflow",  due.flags.queue_overflow,  queue_overflow_i);
          check_field("popped_code",     due.code,                  popped_code_i);
          check_field("popped_valid",    due.flags.popped_valid,    popped_valid_i);
          check_field("queue_empty",     due.flags.queue_empty,     queue_empty_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        results_due.push_back(port_status(ps2hq_op_e'(opcode_i), data_line_i, send_byte_i));
      end
    end
    pending_o        <= results_due.size();
    mismatch_count_o <= mismatches;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 host port regression
// Drives receive frames, send frames, pops and noise into the port under
// several idling patterns and leaves all result checking to the checker.
// ----------------------------------------------------------------------------
module tb_top;

  import ps2hq_pkg::*;

  localparam int Depth       = 16;
  localparam int ItemsTarget = 1450;
  localparam int Phases      = 4;
  // A taken word passes stage one and the output register before its result
  // shows; this is ample slack.
  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 400000;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [1:0] opcode_i       = OP_NOP;
  logic       data_line_i    = 1'b0;
  logic [7:0] send_byte_i    = '0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic       drive_data_low_o;
  logic       request_to_send_o;
  logic       send_rejected_o;
  logic       sending_o;
  logic       send_done_o;
  logic       code_queued_o;
  logic       parity_error_o;
  logic       queue_overflow_o;
  logic [7:0] popped_code_o;
  logic       popped_valid_o;
  logic       queue_empty_o;

  int mismatches;
  int pending;
  int cycles     = 0;
  int words_sent = 0;
  // Idling percentages: idle_pct is the phase setting for the sender,
  // gap_pct the value in force for the current sequence.
  int idle_pct   = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int calm_left  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ps2_host_port_with_queue #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .data_line_i      (data_line_i),
    .send_byte_i      (send_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_data_low_o (drive_data_low_o),
    .request_to_send_o(request_to_send_o),
    .send_rejected_o  (send_rejected_o),
    .sending_o        (sending_o),
    .send_done_o      (send_done_o),
    .code_queued_o    (code_queued_o),
    .parity_error_o   (parity_error_o),
    .queue_overflow_o (queue_overflow_o),
    .popped_code_o    (popped_code_o),
    .popped_valid_o   (popped_valid_o),
    .queue_empty_o    (queue_empty_o)
  );

  ps2hq_result_check #(
    .QUEUE_DEPTH(Depth)
  ) result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .opcode_i        (opcode_i),
    .data_line_i     (data_line_i),
    .send_byte_i     (send_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_data_low_i(drive_data_low_o),
    .request_to_send_i(request_to_send_o),
    .send_rejected_i (send_rejected_o),
    .sending_i       (sending_o),
    .send_done_i     (send_done_o),
    .code_queued_i   (code_queued_o),
    .parity_error_i  (parity_error_o),
    .queue_overflow_i(queue_overflow_o),
    .popped_code_i   (popped_code_o),
    .popped_valid_i  (popped_valid_o),
    .queue_empty_i   (queue_empty_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  // Reset is held from time zero and released on a rising edge.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // The result side stalls at the phase rate, but now and then it opens up
  // for a stretch of cycles so that back-to-back results are seen as well.
  always @(posedge clk_i) begin
    if (calm_left != 0) begin
      calm_left   <= calm_left - 1;
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 63) == 0) begin
      calm_left   <= 24;
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high from one word to the next unless an idle gap is drawn, so valid is
  // never dropped and raised again within one time step.
  task automatic put_word(input ps2hq_op_e op, input logic line, input logic [7:0] byte_in);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_line_i <= line;
    send_byte_i <= byte_in;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // A device clock edge with a random data level; the byte field is ignored
  // on edges, so it is randomized too.
  task automatic clock_edge_word(input logic line);
    put_word(OP_EDGE, line, 8'($urandom));
  endtask

  // A full receive frame from the first bit position: start bit, eight data
  // bits LSB first, the parity bit and the stop bit. Start and stop levels
  // are ignored by the port and therefore random.
  task automatic receive_frame(input logic [7:0] code, input bit good_parity);
    logic par;
    par = ~(^code) ^ !good_parity;
    clock_edge_word(1'($urandom));
    for (int i = 0; i < 8; i++) begin
      clock_edge_word(code[i]);
    end
    clock_edge_word(par);
    clock_edge_word(1'($urandom));
  endtask

  // A send request followed by the edges that carry the data bits, parity
  // and stop bit out and take the acknowledge. With a second request inside
  // the frame the port must refuse it and carry on.
  task automatic send_frame(input logic [7:0] code, input bit with_refusal);
    int refuse_at;
    refuse_at = with_refusal ? $urandom_range(0, 10) : -1;
    put_word(OP_SEND, 1'($urandom), code);
    for (int i = 0; i < 11; i++) begin
      if (i == refuse_at) begin
        put_word(OP_SEND, 1'($urandom), 8'($urandom));
      end
      clock_edge_word(1'($urandom));
    end
  endtask

  task automatic pop_words(input int count);
    repeat (count) put_word(OP_POP, 1'($urandom), 8'($urandom));
  endtask

  // Random words of every kind, after which the frame position is unknown.
  // The first send either starts a frame or is refused because one is under
  // way; in both cases the edges of the first frame leave no send active, and
  // the second send then starts cleanly from the first bit position.
  task automatic noise_and_realign(input int count);
    repeat (count) begin
      put_word(ps2hq_op_e'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
    end
    send_frame(8'($urandom), 1'b0);
    send_frame(8'($urandom), 1'b0);
  endtask

  // More good frames than the ring can hold, so the overflow path is taken,
  // then enough pops to empty it and pop twice more while empty.
  task automatic fill_and_drain();
    repeat (Depth + 1) receive_frame(8'($urandom), 1'b1);
    pop_words(Depth + 1);
  endtask

  // One randomly chosen well-formed sequence, or now and then noise. Each
  // sequence leaves the port at the first bit position of a frame.
  task automatic random_sequence();
    int pick;
    pick    = $urandom_range(0, 99);
    gap_pct = ($urandom_range(0, 9) == 0) ? 0 : idle_pct;
    if (pick < 40) begin
      receive_frame(8'($urandom), $urandom_range(0, 9) != 0);
    end else if (pick < 55) begin
      send_frame(8'($urandom), $urandom_range(0, 3) == 0);
    end else if (pick < 63) begin
      // A send that cuts a receive frame short; the partial byte is lost.
      repeat ($urandom_range(1, 10)) clock_edge_word(1'($urandom));
      send_frame(8'($urandom), 1'b0);
    end else if (pick < 83) begin
      pop_words($urandom_range(1, 3));
    end else if (pick < 88) begin
      put_word(OP_NOP, 1'($urandom), 8'($urandom));
    end else if (pick < 94) begin
      noise_and_realign($urandom_range(1, 8));
    end else if (pick < 95) begin
      fill_and_drain();
    end else begin
      receive_frame(8'($urandom), 1'b1);
    end
  endtask

  // Holds the sender back until every predicted word has come out.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int phase_idle  [Phases] = '{0, 73, 0, 38};
    int phase_stall [Phases] = '{0, 0, 73, 38};
    int directed_words;
    wait (rst_ni);
    @(posedge clk_i);

    // Directed opening: pop and no-op on an empty port, a receive of the
    // all-ones byte, its pop, and a send of the zero byte with a refused
    // second request in the middle of the frame.
    put_word(OP_POP, 1'b1, 8'hFF);
    put_word(OP_NOP, 1'b0, 8'h00);
    receive_frame(8'hFF, 1'b1);
    put_word(OP_POP, 1'b0, 8'h00);
    send_frame(8'h00, 1'b1);
    directed_words = words_sent;

    // Random phases, one per idling pattern. The first opens with a ring
    // overflow. Between phases the sender waits for all results.
    for (int phase = 0; phase < Phases; phase++) begin
      idle_pct  = phase_idle[phase];
      stall_pct = phase_stall[phase];
      if (phase == 0) begin
        fill_and_drain();
      end
      while (words_sent < directed_words +
             (phase + 1) * (ItemsTarget - directed_words) / Phases) begin
        random_sequence();
      end
      wait_for_results();
    end

    // Let any stray result surface before the verdict.
    stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
